### src/sdmd_pkg.sv
// ----------------------------------------------------------------------------
// sdmd_pkg
// Shared types and constants of the sigma-delta motion detection unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sdmd_pkg;

  localparam int PIX_W      = 8;
  localparam int ADDR_W     = 16;
  localparam int AMP_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_ZERO = 8'h00;

  localparam logic [PIX_W-1:0] FLOOR_RST = 8'd2;
  localparam logic [PIX_W-1:0] CEIL_RST  = 8'd254;
  localparam logic [AMP_W-1:0] AMP_RST   = 4'd4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR = 2'd0,
    CFG_CEIL  = 2'd1,
    CFG_AMP   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] floor_val;
    logic [PIX_W-1:0] ceil_val;
    logic [AMP_W-1:0] amp;
  } cfg_t;

  // One input transaction
  typedef struct packed {
    logic              init;
    logic [ADDR_W-1:0] index;
    logic [PIX_W-1:0]  pixel;
  } item_t;

  // One store entry: per-pixel background statistics
  typedef struct packed {
    logic [PIX_W-1:0] variance;
    logic [PIX_W-1:0] mean;
  } entry_t;

  // One result transaction
  typedef struct packed {
    logic [PIX_W-1:0] variance;
    logic [PIX_W-1:0] mean;
    logic [PIX_W-1:0] mask;
  } result_t;

endpackage

`default_nettype wire

### src/sigma_delta_motion_detect_unit.sv
// ----------------------------------------------------------------------------
// sigma_delta_motion_detect_unit
// Sigma-delta background subtraction over a per-pixel mean/variance memory.
// ----------------------------------------------------------------------------
// A result passes the update-stage register and then the result queue.
// Throughput: one pixel per cycle while in_tready is high; the registered read
// of the statistics memory and the update form a two-stage read-modify-write
// loop, with forwarding between back-to-back pixels at the same index.
// Reset: control and configuration registers reset (floor 2, ceiling 254,
// amp 4); the statistics memory is not cleared and holds no data until written.
// ----------------------------------------------------------------------------
`default_nettype none

module sigma_delta_motion_detect_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  // Input stream
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [23:0]                        in_tdata,  // pixel_value, pixel_index
  input  wire                                in_tuser,  // init_frame
  // Result stream
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [23:0]                        out_tdata, // motion_mask, mean_now, variance_now
  // Configuration
  input  wire                                cfg_wr_en,
  input  wire  [sdmd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [sdmd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sdmd_pkg::*;

  cfg_t                   cfg_r;
  item_t                  in_item;
  item_t                  s1_item_r;
  logic                   s1_valid_r;
  logic                   in_accept;
  entry_t                 rd_entry;
  entry_t                 new_entry;
  result_t                upd_result;
  result_t                fifo_data;
  logic [FIFO_CNT_W-1:0]  fifo_cnt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.floor_val <= FLOOR_RST;
      cfg_r.ceil_val  <= CEIL_RST;
      cfg_r.amp       <= AMP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FLOOR: cfg_r.floor_val <= cfg_wdata;
        CFG_CEIL:  cfg_r.ceil_val  <= cfg_wdata;
        CFG_AMP:   cfg_r.amp       <= cfg_wdata[AMP_W-1:0];
        default:   cfg_r           <= cfg_r;
      endcase
    end
  end

  // Unpack the input transaction
  assign in_item.pixel = in_tdata[PIX_W-1:0];
  assign in_item.index = in_tdata[PIX_W+ADDR_W-1:PIX_W];
  assign in_item.init  = in_tuser;

  // Accept while the queue has room for everything in flight; hold off in reset
  assign in_tready = rst_n &&
                     !((fifo_cnt == FIFO_CNT_W'(FIFO_DEPTH)) ||
                       ((fifo_cnt == FIFO_CNT_W'(FIFO_DEPTH - 1)) && s1_valid_r));
  assign in_accept = in_tvalid && in_tready;

  // Update stage: holds the item while its entry is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
  end

  sdmd_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_accept),
    .rd_addr (in_item.index),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_item_r.index),
    .wr_data (new_entry),
    .rd_data (rd_entry)
  );

  sdmd_update u_update (
    .item      (s1_item_r),
    .old_entry (rd_entry),
    .cfg       (cfg_r),
    .new_entry (new_entry),
    .result    (upd_result)
  );

  sdmd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (upd_result),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (fifo_data),
    .count     (fifo_cnt)
  );

  // Pack the result transaction
  assign out_tdata = {fifo_data.variance, fifo_data.mean, fifo_data.mask};

  // Queue never overflows: a full queue leaves the update stage empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (fifo_cnt == FIFO_CNT_W'(FIFO_DEPTH)) |-> !s1_valid_r)
    else $error("result queue full with an item in the update stage");

  // Every accepted transaction reaches the update stage next cycle
  a_accept_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> s1_valid_r)
    else $error("accepted transaction missing from update stage");

  // A read of the entry written in the same cycle sees the written data
  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_valid_r && (in_item.index == s1_item_r.index))
      |=> (rd_entry == $past(new_entry)))
    else $error("back-to-back same-index update not forwarded");

endmodule

`default_nettype wire

### src/sdmd_store.sv
// ----------------------------------------------------------------------------
// sdmd_store
// Statistics memory, one read and one write port, registered read data,
// with write-to-read forwarding for a write and read of the same entry.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmd_store (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          rd_en,
  input  wire  [sdmd_pkg::ADDR_W-1:0]  rd_addr,
  input  wire                          wr_en,
  input  wire  [sdmd_pkg::ADDR_W-1:0]  wr_addr,
  input  sdmd_pkg::entry_t             wr_data,
  output sdmd_pkg::entry_t             rd_data
);
  import sdmd_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  entry_t mem [DEPTH];
  entry_t rd_q_r;
  entry_t fwd_r;
  logic   hit_r;
  logic   hit_nxt;

  // Flag a read of the entry being written in the same cycle
  assign hit_nxt = rd_en && wr_en && (rd_addr == wr_addr);

  // Write back and read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Hold the forwarded entry
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (rd_en) begin
      hit_r <= hit_nxt;
    end
  end

  assign rd_data = hit_r ? fwd_r : rd_q_r;

endmodule

`default_nettype wire

### src/sdmd_update.sv
// ----------------------------------------------------------------------------
// sdmd_update
// Per-pixel update: mean and variance step, clamp and foreground decision.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmd_update (
  input  sdmd_pkg::item_t   item,
  input  sdmd_pkg::entry_t  old_entry,
  input  sdmd_pkg::cfg_t    cfg,
  output sdmd_pkg::entry_t  new_entry,
  output sdmd_pkg::result_t result
);
  import sdmd_pkg::*;

  localparam int PROD_W = PIX_W + AMP_W;

  logic [PIX_W-1:0]  mean_step;
  logic [PIX_W-1:0]  diff;
  logic [PROD_W-1:0] prod;
  logic [PIX_W-1:0]  target;
  logic [PIX_W-1:0]  var_step;
  logic [PIX_W-1:0]  var_ceil;
  logic [PIX_W-1:0]  var_clamp;
  logic [PIX_W-1:0]  mean_out;
  logic [PIX_W-1:0]  var_out;
  logic [PIX_W-1:0]  mask_out;

  // Move one level toward the target
  function automatic logic [PIX_W-1:0] toward(input logic [PIX_W-1:0] cur,
                                               input logic [PIX_W-1:0] tgt);
    logic [PIX_W-1:0] res;
    if (cur < tgt) begin
      res = cur + PIX_W'(1);
    end else if (cur > tgt) begin
      res = cur - PIX_W'(1);
    end else begin
      res = cur;
    end
    return res;
  endfunction

  // Mean step and absolute difference against the new mean
  always_comb begin
    mean_step = toward(old_entry.mean, item.pixel);
    diff      = (mean_step > item.pixel) ? (mean_step - item.pixel)
                                         : (item.pixel - mean_step);
  end

  // Saturated target, variance step, clamp ceiling first then floor
  always_comb begin
    prod      = PROD_W'(diff) * PROD_W'(cfg.amp);
    target    = (prod > PROD_W'(PIX_MAX)) ? PIX_MAX : prod[PIX_W-1:0];
    var_step  = toward(old_entry.variance, target);
    var_ceil  = (var_step > cfg.ceil_val) ? cfg.ceil_val : var_step;
    var_clamp = (var_ceil < cfg.floor_val) ? cfg.floor_val : var_ceil;
  end

  // Select init load or normal update
  always_comb begin
    if (item.init) begin
      mean_out = item.pixel;
      var_out  = cfg.floor_val;
      mask_out = PIX_ZERO;
    end else begin
      mean_out = mean_step;
      var_out  = var_clamp;
      mask_out = (diff >= var_clamp) ? PIX_MAX : PIX_ZERO;
    end
  end

  assign new_entry.mean     = mean_out;
  assign new_entry.variance = var_out;
  assign result.mask        = mask_out;
  assign result.mean        = mean_out;
  assign result.variance    = var_out;

endmodule

`default_nettype wire

### src/sdmd_out_fifo.sv
// ----------------------------------------------------------------------------
// sdmd_out_fifo
// Three-entry result queue that decouples the update pipe from the
// result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module sdmd_out_fifo (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              push,
  input  sdmd_pkg::result_t                push_data,
  input  wire                              pop_ready,
  output logic                             pop_valid,
  output sdmd_pkg::result_t                pop_data,
  output logic [sdmd_pkg::FIFO_CNT_W-1:0]  count
);
  import sdmd_pkg::*;

  result_t                entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                   pop;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    logic [FIFO_PTR_W-1:0] res;
    if (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + FIFO_PTR_W'(1);
    end
    return res;
  endfunction

  assign pop = pop_valid && pop_ready;

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr_r] <= push_data;
    end
  end

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = entries[rd_ptr_r];
  assign count     = cnt_r;

endmodule

`default_nettype wire
